>>> sv/tdhq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdhq_pkg
// shared types and constants of the trigger delay/hold qualifier
// ---------------------------------------------------------------------------
package tdhq_pkg;

    localparam int ADDR_SLOTS = 16;
    localparam int SLOT_W     = 4;
    localparam int OP_W       = 2;
    localparam int STATE_W    = 2;
    localparam int DATA_W     = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_LOAD   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [STATE_W-1:0] {
        ST_RESET    = 2'd0,
        ST_PRESET   = 2'd1,
        ST_SET      = 2'd2,
        ST_PRERESET = 2'd3
    } slot_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_OP,
        CS_WALK,
        CS_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic do_op;
        logic walk_step;
        logic flush;
    } ctrl_t;

    typedef struct packed {
        logic start_tick;
        logic walk_end;
    } status_t;

endpackage : tdhq_pkg
`default_nettype wire

>>> sv/tdhq_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdhq_ctrl
// sequencer: one op state for non-tick commands, slot walk on tick, final result flush
// ---------------------------------------------------------------------------
module tdhq_ctrl
    import tdhq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        unique case (state_reg)
            CS_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = status.start_tick ? CS_WALK : CS_OP;
                end
            end
            CS_OP:
            begin
                ctrl.do_op = 1'b1;
                state_next = CS_IDLE;
            end
            CS_WALK:
            begin
                ctrl.walk_step = 1'b1;
                if (status.walk_end)
                begin
                    state_next = CS_FLUSH;
                end
            end
            CS_FLUSH:
            begin
                ctrl.flush = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule : tdhq_ctrl
`default_nettype wire

>>> sv/tdhq_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdhq_datapath
// slot tables, item registers, walk index and result registers
// ---------------------------------------------------------------------------
module tdhq_datapath
    import tdhq_pkg::*;
#(
    parameter int NUM_SLOTS  = 16,
    parameter int TIME_WIDTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_t             ctrl,
    output status_t                status,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic              occurred,
    input  wire logic [DATA_W-1:0] detect_ticks,
    input  wire logic [DATA_W-1:0] hold_ticks,
    output logic                   strobe,
    output logic [SLOT_W-1:0]      out_slot,
    output logic [STATE_W-1:0]     out_state,
    output logic                   notify,
    output logic                   last
);

    localparam int WALK_SLOTS = (NUM_SLOTS < ADDR_SLOTS) ? NUM_SLOTS : ADDR_SLOTS;
    localparam int IDX_W      = (WALK_SLOTS > 1) ? $clog2(WALK_SLOTS) : 1;

    // slot tables
    logic                  valid_reg  [WALK_SLOTS];
    slot_state_t           sstate_reg [WALK_SLOTS];
    logic [TIME_WIDTH-1:0] rem_reg    [WALK_SLOTS];
    logic [TIME_WIDTH-1:0] detect_mem [WALK_SLOTS];
    logic [TIME_WIDTH-1:0] hold_mem   [WALK_SLOTS];

    // captured item
    op_t                   op_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  occ_reg;
    logic [TIME_WIDTH-1:0] dt_reg;
    logic [TIME_WIDTH-1:0] ht_reg;

    logic [IDX_W-1:0]      walk_idx_reg;

    // pending walk result, held until the next one or the flush
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [SLOT_W-1:0]     pend_slot_reg;
    logic [SLOT_W-1:0]     pend_slot_next;
    slot_state_t           pend_state_reg;
    slot_state_t           pend_state_next;

    logic                  strobe_reg;
    logic                  strobe_next;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [SLOT_W-1:0]     out_slot_next;
    slot_state_t           out_state_reg;
    slot_state_t           out_state_next;
    logic                  notify_reg;
    logic                  notify_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  in_table;
    logic [IDX_W-1:0]      rd_idx;
    logic                  cur_valid;
    slot_state_t           cur_state;
    logic [TIME_WIDTH-1:0] cur_rem;
    logic [TIME_WIDTH-1:0] rem_dec;
    logic                  tab_we;
    logic                  time_we;
    logic                  new_valid;
    slot_state_t           new_state;
    logic [TIME_WIDTH-1:0] new_rem;
    logic                  changed;

    assign in_table = int'(slot_reg) < NUM_SLOTS;
    assign rd_idx   = ctrl.walk_step ? walk_idx_reg : slot_reg[IDX_W-1:0];

    assign cur_valid = valid_reg[rd_idx];
    assign cur_state = sstate_reg[rd_idx];
    assign cur_rem   = rem_reg[rd_idx];
    assign rem_dec   = (cur_rem != '0) ? cur_rem - TIME_WIDTH'(1) : '0;

    assign status.start_tick = op_t'(op) == OP_TICK;
    assign status.walk_end   = walk_idx_reg == IDX_W'(WALK_SLOTS - 1);

    // table update for the current beat
    always_comb
    begin
        tab_we    = 1'b0;
        time_we   = 1'b0;
        new_valid = cur_valid;
        new_state = cur_state;
        new_rem   = cur_rem;
        changed   = 1'b0;
        if (ctrl.walk_step)
        begin
            if (cur_valid && cur_state != ST_RESET)
            begin
                tab_we  = 1'b1;
                new_rem = rem_dec;
                if (rem_dec == '0)
                begin
                    if (cur_state == ST_PRESET)
                    begin
                        new_state = ST_SET;
                        new_rem   = hold_mem[rd_idx];
                        changed   = 1'b1;
                    end
                    else if (cur_state == ST_PRERESET)
                    begin
                        new_state = ST_RESET;
                        changed   = 1'b1;
                    end
                end
            end
        end
        else if (ctrl.do_op && in_table)
        begin
            case (op_reg)
                OP_UPDATE:
                begin
                    if (cur_valid)
                    begin
                        tab_we = 1'b1;
                        case (cur_state)
                            ST_RESET:
                            begin
                                if (occ_reg)
                                begin
                                    new_state = ST_PRESET;
                                    new_rem   = detect_mem[rd_idx];
                                end
                            end
                            ST_PRESET:
                            begin
                                if (!occ_reg)
                                begin
                                    new_state = ST_RESET;
                                    new_rem   = '0;
                                end
                            end
                            ST_SET:
                            begin
                                if (!occ_reg)
                                begin
                                    new_state = ST_PRERESET;
                                end
                            end
                            default:
                            begin
                                if (occ_reg)
                                begin
                                    new_state = ST_SET;
                                end
                            end
                        endcase
                    end
                end
                OP_LOAD:
                begin
                    tab_we    = 1'b1;
                    time_we   = 1'b1;
                    new_valid = 1'b1;
                    new_state = ST_RESET;
                    new_rem   = '0;
                end
                OP_REMOVE:
                begin
                    tab_we    = 1'b1;
                    new_valid = 1'b0;
                    new_state = ST_RESET;
                    new_rem   = '0;
                end
                default:
                begin
                    tab_we = 1'b0;
                end
            endcase
        end
    end

    // result sequencing
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_state_next = pend_state_reg;
        strobe_next     = 1'b0;
        out_slot_next   = out_slot_reg;
        out_state_next  = out_state_reg;
        notify_next     = notify_reg;
        last_next       = last_reg;
        if (ctrl.do_op)
        begin
            strobe_next    = 1'b1;
            out_slot_next  = slot_reg;
            out_state_next = (op_reg == OP_UPDATE && in_table && cur_valid) ? new_state
                                                                             : ST_RESET;
            notify_next    = 1'b0;
            last_next      = 1'b1;
        end
        else if (ctrl.walk_step && changed)
        begin
            if (pend_valid_reg)
            begin
                strobe_next    = 1'b1;
                out_slot_next  = pend_slot_reg;
                out_state_next = pend_state_reg;
                notify_next    = 1'b1;
                last_next      = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = SLOT_W'(walk_idx_reg);
            pend_state_next = new_state;
        end
        else if (ctrl.flush)
        begin
            if (pend_valid_reg)
            begin
                strobe_next    = 1'b1;
                out_slot_next  = pend_slot_reg;
                out_state_next = pend_state_reg;
                notify_next    = 1'b1;
                last_next      = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WALK_SLOTS; i++)
            begin
                valid_reg[i]  <= 1'b0;
                sstate_reg[i] <= ST_RESET;
                rem_reg[i]    <= '0;
            end
            walk_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            if (tab_we)
            begin
                valid_reg[rd_idx]  <= new_valid;
                sstate_reg[rd_idx] <= new_state;
                rem_reg[rd_idx]    <= new_rem;
            end
            if (ctrl.capture)
            begin
                walk_idx_reg <= '0;
            end
            else if (ctrl.walk_step)
            begin
                walk_idx_reg <= walk_idx_reg + IDX_W'(1);
            end
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (time_we)
        begin
            detect_mem[rd_idx] <= dt_reg;
            hold_mem[rd_idx]   <= ht_reg;
        end
        if (ctrl.capture)
        begin
            op_reg   <= op_t'(op);
            slot_reg <= slot;
            occ_reg  <= occurred;
            dt_reg   <= TIME_WIDTH'(detect_ticks);
            ht_reg   <= TIME_WIDTH'(hold_ticks);
        end
        pend_slot_reg  <= pend_slot_next;
        pend_state_reg <= pend_state_next;
        out_slot_reg   <= out_slot_next;
        out_state_reg  <= out_state_next;
        notify_reg     <= notify_next;
        last_reg       <= last_next;
    end

    assign strobe    = strobe_reg;
    assign out_slot  = out_slot_reg;
    assign out_state = out_state_reg;
    assign notify    = notify_reg;
    assign last      = last_reg;

endmodule : tdhq_datapath
`default_nettype wire

>>> sv/trigger_delay_hold_qualifier_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// trigger_delay_hold_qualifier_unit
// on-delay / off-delay qualifier over a table of trigger slots
// ---------------------------------------------------------------------------
// usage:
//   command channel: drive op, slot, occurred, detect_ticks, hold_ticks and
//   raise start; the beat is taken at a clock edge with start high and busy
//   low. busy stays high until the command has finished.
//   result channel: each result appears for one cycle with strobe high on
//   out_slot, out_state, notify, last; the receiver cannot stall it and must
//   take every beat. last marks the final result of a command.
//   update, load, remove: one result, registered from the op state entered on
//   acceptance; the next command can be accepted once busy is low again.
//   tick: the slot table is walked one slot per cycle over min(NUM_SLOTS,16)
//   slots, then a flush state; each slot that changes state yields one
//   result, held back until the next change or the end of the walk so the
//   final one can carry last; a tick with no change yields no result.
//   reset: all slots invalid and in reset state, no results pending.
// ---------------------------------------------------------------------------
module trigger_delay_hold_qualifier_unit
    import tdhq_pkg::*;
#(
    parameter int NUM_SLOTS  = 16,
    parameter int TIME_WIDTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic              occurred,
    input  wire logic [DATA_W-1:0] detect_ticks,
    input  wire logic [DATA_W-1:0] hold_ticks,
    output logic                   strobe,
    output logic [SLOT_W-1:0]      out_slot,
    output logic [STATE_W-1:0]     out_state,
    output logic                   notify,
    output logic                   last
);

    ctrl_t   ctrl;
    status_t status;

    tdhq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .ctrl   (ctrl)
    );

    tdhq_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .op           (op),
        .slot         (slot),
        .occurred     (occurred),
        .detect_ticks (detect_ticks),
        .hold_ticks   (hold_ticks),
        .strobe       (strobe),
        .out_slot     (out_slot),
        .out_state    (out_state),
        .notify       (notify),
        .last         (last)
    );

endmodule : trigger_delay_hold_qualifier_unit
`default_nettype wire
